// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the sorted line table.
// No dependencies; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while the asynchronous reset is asserted.
`define ASSERT_CLK_RST(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/slt_pkg.sv =====
// Package of the sorted line table: sizes, request and status codes, states.
// No dependencies; used by sorted_line_table_top and its testbench.
`timescale 1ns / 1ps

package slt_pkg;

	// default sizing
	localparam int CAPACITY_DEF       = 256;
	localparam int KEY_BITS_DEF       = 16;
	localparam int ENTRY_OVERHEAD_DEF = 32;
	localparam int LEN_BITS_DEF       = 10;

	// fixed field widths on the ports
	localparam int REQ_W    = 2;
	localparam int KEY_W    = 16;
	localparam int HANDLE_W = 16;
	localparam int LENGTH_W = 10;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 9;
	localparam int HELD_W   = 9;
	localparam int BYTES_W  = 24;

	// budget arithmetic width: limit plus one length plus overhead fits
	localparam int BUD_W = BYTES_W + 2;

	localparam int IN_FIELDS_W  = KEY_W + HANDLE_W + LENGTH_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + INDEX_W + HANDLE_W + LENGTH_W + HELD_W + BYTES_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [BYTES_W-1:0] LIMIT_RESET = 24'd65536;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_LIMIT    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_CHECK,
		S_UP,
		S_DOWN,
		S_RESP
	} state_t;

endpackage

// ===== hw/rtl/slt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; instanced by sorted_line_table_top for the entry store.
`timescale 1ns / 1ps

module slt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/sorted_line_table_top.sv =====
// Top level of the sorted line table: sequencer, budget logic and entry RAM.
// Depends on slt_pkg, slt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sorted line table. Holds up to CAPACITY program lines sorted by line key,
// each with a text handle and a text length, in one RAM with a registered
// read. One request is in work at a time: s_tready is high only while the
// sequencer is idle. Clear goes straight to the result state. Every other
// request runs a lower-bound binary search, each halving step an issue-read
// state and a compare state, then reads the candidate, decides in the check
// state and goes to the result state. An insert of a new key then shifts the
// higher entries up and writes the new one, a delete shifts them down, one
// entry per cycle through the single read and write port of the RAM. The
// result sits in an output register, so the next request may enter while it
// waits. The byte budget counts each text length plus ENTRY_OVERHEAD against
// byte_limit, written over cfg_we/cfg_wdata (reset 65536); the user must write
// it only while the block is idle, which the block itself does not enforce.
// Entries at or above the held count are never used, so the RAM needs no clearing.
module sorted_line_table_top
	import slt_pkg::*;
#(
	parameter int CAPACITY       = CAPACITY_DEF,
	parameter int KEY_BITS       = KEY_BITS_DEF,
	parameter int ENTRY_OVERHEAD = ENTRY_OVERHEAD_DEF,
	parameter int LEN_BITS       = LEN_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: byte_limit
	input  logic                  cfg_we,
	input  logic [BYTES_W-1:0]    cfg_wdata,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata: line_key[15:0], text_handle[31:16], text_length[41:32], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [REQ_W-1:0]      s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: status[1:0], entry_index[10:2], found_handle[26:11],
	// found_length[36:27], entries_held[45:37], bytes_in_use[69:46], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW      = $clog2(CAPACITY);
	localparam int IDX_W   = $clog2(CAPACITY + 1);
	localparam int ENTRY_W = KEY_BITS + LEN_BITS + HANDLE_W;
	localparam int PAD_W   = OUT_DATA_W - OUT_FIELDS_W;

	state_t state_q, state_d;

	// request registers
	req_t                  req_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [LEN_BITS-1:0]   len_q;

	// search and shift pointers
	logic [IDX_W-1:0] lo_q, hi_q, mid_q, i_q, j_q;
	logic [AW-1:0]    wa_q;
	logic             pend_q;

	// table state and result staging
	logic [IDX_W-1:0]    count_q;
	logic [BYTES_W-1:0]  used_q, nu_q, limit_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] fh_q;
	logic [LEN_BITS-1:0] fl_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// RAM port
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic [KEY_BITS-1:0] rd_key;
	logic [LEN_BITS-1:0] rd_len;
	logic [HANDLE_W-1:0] rd_handle;

	logic [IDX_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid;
	logic [IDX_W-1:0]   i_dec, j_dec;
	logic               hit;
	logic [BUD_W-1:0]   rep_nu, new_nu, del_cost, del_nu, limit_ext, used_ext;
	logic [ENTRY_W-1:0] new_entry;
	logic               accept, out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	assign rd_key    = ram_rdata[KEY_BITS-1:0];
	assign rd_len    = ram_rdata[KEY_BITS +: LEN_BITS];
	assign rd_handle = ram_rdata[KEY_BITS+LEN_BITS +: HANDLE_W];
	assign new_entry = {handle_q, len_q, key_q};

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign i_dec   = i_q - 1'b1;
	assign j_dec   = j_q - 1'b1;

	assign hit = (lo_q < count_q) && (rd_key == key_q);

	// budget arithmetic on the entry just read
	assign used_ext  = BUD_W'(used_q);
	assign limit_ext = BUD_W'(limit_q);
	assign rep_nu    = (used_ext < BUD_W'(rd_len)) ? BUD_W'(len_q)
	                 : used_ext - BUD_W'(rd_len) + BUD_W'(len_q);
	assign new_nu    = used_ext + BUD_W'(len_q) + BUD_W'(ENTRY_OVERHEAD);
	assign del_cost  = BUD_W'(rd_len) + BUD_W'(ENTRY_OVERHEAD);
	assign del_nu    = (used_ext > del_cost) ? used_ext - del_cost : '0;

	slt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = lo_q[AW-1:0];
		ram_wdata = new_entry;
		ram_raddr = lo_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (req_t'(s_tuser) == REQ_CLEAR) ? S_RESP : S_SEARCH;
				end
			end
			S_SEARCH: begin
				// read the midpoint while the range is open, else the candidate
				if (lo_q < hi_q) begin
					ram_raddr = mid[AW-1:0];
					state_d   = S_CMP;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CMP: begin
				state_d = S_SEARCH;
			end
			S_CHECK: begin
				state_d = S_RESP;
				case (req_q)
					REQ_INSERT: begin
						if (hit) begin
							// replace in place when the budget allows
							ram_we = (rep_nu <= limit_ext);
						end else if (new_nu <= limit_ext &&
						             count_q != IDX_W'(CAPACITY)) begin
							state_d = S_UP;
						end
					end
					REQ_DELETE: begin
						if (hit) begin
							state_d = S_DOWN;
						end
					end
					default: begin
					end
				endcase
			end
			S_UP: begin
				// read below, write the entry read last cycle one slot higher
				ram_raddr = i_dec[AW-1:0];
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = wa_q;
					ram_wdata = ram_rdata;
				end else if (i_q == lo_q) begin
					ram_we  = 1'b1;
					state_d = S_RESP;
				end
			end
			S_DOWN: begin
				// read above, write the entry read last cycle one slot lower
				ram_raddr = j_q[AW-1:0];
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = wa_q;
					ram_wdata = ram_rdata;
				end else if (!(j_q < count_q)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// table state and budget
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
			limit_q <= LIMIT_RESET;
			pend_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req_t'(s_tuser) == REQ_CLEAR) begin
						count_q <= '0;
						used_q  <= '0;
					end
				end
				S_CHECK: begin
					pend_q <= 1'b0;
					if (req_q == REQ_INSERT && hit && rep_nu <= limit_ext) begin
						used_q <= rep_nu[BYTES_W-1:0];
					end
					if (req_q == REQ_DELETE && hit) begin
						used_q <= del_nu[BYTES_W-1:0];
					end
				end
				S_UP: begin
					if (i_q > lo_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q <= count_q + 1'b1;
							used_q  <= nu_q;
						end
					end
				end
				S_DOWN: begin
					if (j_q < count_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request, pointers and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q    <= req_t'(s_tuser);
					key_q    <= KEY_BITS'(s_tdata[KEY_W-1:0]);
					handle_q <= s_tdata[KEY_W +: HANDLE_W];
					len_q    <= LEN_BITS'(s_tdata[KEY_W+HANDLE_W +: LENGTH_W]);
					lo_q     <= '0;
					hi_q     <= count_q;
					status_q <= ST_OK;
					fh_q     <= '0;
					fl_q     <= '0;
				end
			end
			S_SEARCH: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if (rd_key < key_q) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_CHECK: begin
				i_q  <= count_q;
				j_q  <= lo_q + 1'b1;
				nu_q <= new_nu[BYTES_W-1:0];
				case (req_q)
					REQ_INSERT: begin
						if (hit) begin
							if (rep_nu > limit_ext) begin
								status_q <= ST_LIMIT;
							end
						end else if (new_nu > limit_ext) begin
							status_q <= ST_LIMIT;
						end else if (count_q == IDX_W'(CAPACITY)) begin
							status_q <= ST_FULL;
						end
					end
					REQ_DELETE: begin
						if (!hit) begin
							status_q <= ST_NOTFOUND;
						end
					end
					REQ_LOOKUP: begin
						if (!hit) begin
							status_q <= ST_NOTFOUND;
						end else begin
							fh_q <= rd_handle;
							fl_q <= rd_len;
						end
					end
					default: begin
					end
				endcase
			end
			S_UP: begin
				if (i_q > lo_q) begin
					wa_q <= i_q[AW-1:0];
					i_q  <= i_dec;
				end
			end
			S_DOWN: begin
				if (j_q < count_q) begin
					wa_q <= j_dec[AW-1:0];
					j_q  <= j_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: load the staged result, hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			m_tdata_q <= {{PAD_W{1'b0}},
			              used_q,
			              HELD_W'(count_q),
			              LENGTH_W'(fl_q),
			              fh_q,
			              INDEX_W'(lo_q),
			              status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_CLK_RST(a_count_in_range, clk, arst_n, count_q <= IDX_W'(CAPACITY), "entry count above capacity")
	`ASSERT_CLK_RST(a_accept_busy, clk, arst_n, accept |=> !s_tready, "request taken while busy")
	`ASSERT_CLK_RST(a_ram_write_state, clk, arst_n,
		ram_we |-> (state_q == S_CHECK || state_q == S_UP || state_q == S_DOWN),
		"RAM write outside update states")
	`ASSERT_CLK_RST(a_up_bound, clk, arst_n, (state_q == S_UP) |-> (i_q >= lo_q),
		"shift pointer below insertion point")
	`ASSERT_CLK_RST(a_resp_load, clk, arst_n, (state_q == S_RESP && out_free) |=> m_tvalid,
		"result not presented")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of sorted_line_table_top: directed table, fill to capacity,
// then random request streams, scored against typed rows or an in-bench predictor.
// Depends on slt_pkg and the RTL of sorted_line_table_top.
`timescale 1ns / 1ps

module tb;
	import slt_pkg::*;

	localparam int TABLE_DEPTH = CAPACITY_DEF;
	localparam int QUIET_LIMIT = 4000;   // cycles with no transfer on either side
	localparam int DRAIN_TAIL  = 300;    // idle tail after the last result is taken

	// one result, unpacked field by field from m_tdata
	typedef struct packed {
		status_t              status;
		logic [INDEX_W-1:0]   entry_idx;
		logic [HANDLE_W-1:0]  found_handle;
		logic [LENGTH_W-1:0]  found_length;
		logic [HELD_W-1:0]    held;
		logic [BYTES_W-1:0]   bytes_used;
	} line_result_t;

	// one row of the directed table: a limit write or a request
	typedef struct {
		bit                   is_cfg;
		logic [BYTES_W-1:0]   cfg_val;
		req_t                 req;
		logic [KEY_W-1:0]     key;
		logic [HANDLE_W-1:0]  handle;
		logic [LENGTH_W-1:0]  len;
		bit                   typed;
		line_result_t         want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [BYTES_W-1:0]    cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [REQ_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predicted table contents
	logic [KEY_W-1:0]      keys_held    [TABLE_DEPTH];
	logic [HANDLE_W-1:0]   handles_held [TABLE_DEPTH];
	logic [LENGTH_W-1:0]   lengths_held [TABLE_DEPTH];
	int                    held_count   = 0;
	longint                budget_used  = 0;
	longint                budget_limit = LIMIT_RESET;

	line_result_t          pending_results [$];
	int                    mismatches  = 0;
	int                    quiet_cycles = 0;
	int                    tx_idle_pct = 37;
	int                    rx_idle_pct = 47;

	stim_row_t             directed_rows [$];

	sorted_line_table_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the predicted table and return the result it gives.
	function automatic line_result_t table_apply(req_t req, logic [KEY_W-1:0] key,
			logic [HANDLE_W-1:0] handle, logic [LENGTH_W-1:0] len);
		line_result_t res;
		int           lo;
		int           hi;
		int           mid;
		bit           hit;
		longint       next_used;
		res = '0;
		res.status = ST_OK;
		if (req == REQ_CLEAR) begin
			held_count = 0;
			budget_used = 0;
		end else begin
			// lower bound over the held entries
			lo = 0;
			hi = held_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (keys_held[mid] < key)
					lo = mid + 1;
				else
					hi = mid;
			end
			hit = (lo < held_count) && (keys_held[lo] == key);
			res.entry_idx = lo[INDEX_W-1:0];
			if (req == REQ_INSERT) begin
				if (hit) begin
					// replace: swap the old length for the new one
					if (budget_used < lengths_held[lo])
						next_used = len;
					else
						next_used = budget_used - lengths_held[lo] + len;
					if (next_used > budget_limit) begin
						res.status = ST_LIMIT;
					end else begin
						handles_held[lo] = handle;
						lengths_held[lo] = len;
						budget_used = next_used;
					end
				end else begin
					// budget is checked ahead of capacity
					next_used = budget_used + len + ENTRY_OVERHEAD_DEF;
					if (next_used > budget_limit) begin
						res.status = ST_LIMIT;
					end else if (held_count >= TABLE_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						for (int i = held_count; i > lo; i--) begin
							keys_held[i] = keys_held[i-1];
							handles_held[i] = handles_held[i-1];
							lengths_held[i] = lengths_held[i-1];
						end
						keys_held[lo] = key;
						handles_held[lo] = handle;
						lengths_held[lo] = len;
						held_count++;
						budget_used = next_used;
					end
				end
			end else if (!hit) begin
				res.status = ST_NOTFOUND;
			end else if (req == REQ_DELETE) begin
				next_used = lengths_held[lo] + ENTRY_OVERHEAD_DEF;
				budget_used = (budget_used > next_used) ? budget_used - next_used : 0;
				for (int i = lo; i + 1 < held_count; i++) begin
					keys_held[i] = keys_held[i+1];
					handles_held[i] = handles_held[i+1];
					lengths_held[i] = lengths_held[i+1];
				end
				held_count--;
			end else begin
				res.found_handle = handles_held[lo];
				res.found_length = lengths_held[lo];
			end
		end
		res.held = held_count[HELD_W-1:0];
		res.bytes_used = budget_used[BYTES_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t req_row(req_t req, logic [KEY_W-1:0] key,
			logic [HANDLE_W-1:0] handle, logic [LENGTH_W-1:0] len);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_val = '0;
		row.req = req;
		row.key = key;
		row.handle = handle;
		row.len = len;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t typed_row(req_t req, logic [KEY_W-1:0] key,
			logic [HANDLE_W-1:0] handle, logic [LENGTH_W-1:0] len, status_t st,
			int idx, logic [HANDLE_W-1:0] fh, int fl, int held, int bytes_used);
		stim_row_t row;
		row = req_row(req, key, handle, len);
		row.typed = 1'b1;
		row.want.status = st;
		row.want.entry_idx = idx[INDEX_W-1:0];
		row.want.found_handle = fh;
		row.want.found_length = fl[LENGTH_W-1:0];
		row.want.held = held[HELD_W-1:0];
		row.want.bytes_used = bytes_used[BYTES_W-1:0];
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [BYTES_W-1:0] limit);
		stim_row_t row;
		row = req_row(REQ_LOOKUP, '0, '0, '0);
		row.is_cfg = 1'b1;
		row.cfg_val = limit;
		return row;
	endfunction

	task automatic flag_mismatch(string what, line_result_t want, line_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("mismatch (%s): expected st=%0d idx=%0d fh=%h fl=%0d held=%0d bytes=%0d",
				what, want.status, want.entry_idx, want.found_handle, want.found_length,
				want.held, want.bytes_used);
			$display(", got st=%0d idx=%0d fh=%h fl=%0d held=%0d bytes=%0d",
				got.status, got.entry_idx, got.found_handle, got.found_length,
				got.held, got.bytes_used);
		end
	endtask

	// Present one request, hold it until the transfer, then record its expected result.
	task automatic send_req(req_t req, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle,
			logic [LENGTH_W-1:0] len, bit typed, line_result_t want);
		line_result_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= IN_DATA_W'({len, handle, key});
		do
			@(posedge clk);
		while (!s_tready);
		predicted = table_apply(req, key, handle, len);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Drop valid and hold until every outstanding result has been taken.
	task automatic wait_results_in();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [BYTES_W-1:0] limit);
		wait_results_in();
		cfg_we <= 1'b1;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		budget_limit = limit;
	endtask

	// Random requests: mostly keys already held or right next to one, so that
	// replaces, deletes and mid-table shifts dominate over plain misses.
	task automatic run_random_phase(int count);
		req_t             req;
		logic [KEY_W-1:0] key;
		logic [LENGTH_W-1:0] len;
		int               pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(999);
			if (pick < 3)
				req = REQ_CLEAR;
			else if (pick < 503)
				req = REQ_INSERT;
			else if (pick < 653)
				req = REQ_DELETE;
			else
				req = REQ_LOOKUP;
			pick = $urandom_range(99);
			if (held_count != 0 && pick < 50)
				key = keys_held[$urandom_range(held_count - 1)];
			else if (held_count != 0 && pick < 65)
				key = keys_held[$urandom_range(held_count - 1)] + 16'd1;
			else if (pick < 85)
				key = KEY_W'($urandom_range(1023));
			else if (pick < 90)
				key = pick[0] ? '1 : '0;
			else
				key = KEY_W'($urandom);
			len = ($urandom_range(9) < 7) ? LENGTH_W'($urandom) : LENGTH_W'($urandom_range(63));
			send_req(req, key, HANDLE_W'($urandom), len, 1'b0, '0);
			// now and then let the pipe run dry before going on
			if ($urandom_range(49) == 0)
				wait_results_in();
		end
	endtask

	// Score every result transfer against the oldest expectation.
	always @(posedge clk) begin
		line_result_t got;
		line_result_t want;
		string        bad;
		if (m_tvalid && m_tready) begin
			got.status = status_t'(m_tdata[1:0]);
			got.entry_idx = m_tdata[10:2];
			got.found_handle = m_tdata[26:11];
			got.found_length = m_tdata[36:27];
			got.held = m_tdata[45:37];
			got.bytes_used = m_tdata[69:46];
			if (pending_results.size() == 0) begin
				flag_mismatch("no request pending", '0, got);
			end else begin
				want = pending_results.pop_front();
				bad = "";
				if (got.status !== want.status)
					bad = {bad, " status"};
				if (got.entry_idx !== want.entry_idx)
					bad = {bad, " entry_index"};
				if (got.found_handle !== want.found_handle)
					bad = {bad, " found_handle"};
				if (got.found_length !== want.found_length)
					bad = {bad, " found_length"};
				if (got.held !== want.held)
					bad = {bad, " entries_held"};
				if (got.bytes_used !== want.bytes_used)
					bad = {bad, " bytes_in_use"};
				if (bad != "")
					flag_mismatch(bad, want, got);
			end
		end
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t row;
		logic [7:0] slot;

		// directed part, limit at its reset value
		directed_rows.push_back(typed_row(REQ_LOOKUP, 16'h0000, 16'h0000, 10'd0,
			ST_NOTFOUND, 0, 16'h0000, 0, 0, 0));
		directed_rows.push_back(typed_row(REQ_DELETE, 16'hFFFF, 16'hFFFF, 10'd1023,
			ST_NOTFOUND, 0, 16'h0000, 0, 0, 0));
		directed_rows.push_back(typed_row(REQ_INSERT, 16'h8000, 16'hFFFF, 10'd1023,
			ST_OK, 0, 16'h0000, 0, 1, 1055));
		directed_rows.push_back(typed_row(REQ_INSERT, 16'h0000, 16'h0000, 10'd0,
			ST_OK, 0, 16'h0000, 0, 2, 1087));
		directed_rows.push_back(typed_row(REQ_INSERT, 16'hFFFF, 16'hAAAA, 10'h155,
			ST_OK, 2, 16'h0000, 0, 3, 1460));
		directed_rows.push_back(typed_row(REQ_LOOKUP, 16'hFFFF, 16'h0000, 10'd0,
			ST_OK, 2, 16'hAAAA, 'h155, 3, 1460));
		directed_rows.push_back(req_row(REQ_LOOKUP, 16'h8000, 16'h1234, 10'd7));
		directed_rows.push_back(req_row(REQ_INSERT, 16'h8000, 16'h5555, 10'h2AA));
		directed_rows.push_back(req_row(REQ_LOOKUP, 16'h7FFF, 16'h0000, 10'd0));
		directed_rows.push_back(req_row(REQ_DELETE, 16'h0000, 16'h0000, 10'd0));
		directed_rows.push_back(req_row(REQ_DELETE, 16'h0000, 16'h0000, 10'd0));
		directed_rows.push_back(req_row(REQ_LOOKUP, 16'h8000, 16'h0000, 10'd0));
		// clear ignores key, handle and length
		directed_rows.push_back(typed_row(REQ_CLEAR, 16'h1234, 16'h5678, 10'd1023,
			ST_OK, 0, 16'h0000, 0, 0, 0));
		directed_rows.push_back(typed_row(REQ_LOOKUP, 16'h8000, 16'h0000, 10'd0,
			ST_NOTFOUND, 0, 16'h0000, 0, 0, 0));
		// tight budget: exact fit, new entry over budget, replace over budget, replace that fits
		directed_rows.push_back(cfg_row(24'd100));
		directed_rows.push_back(typed_row(REQ_INSERT, 16'd10, 16'd1, 10'd68,
			ST_OK, 0, 16'h0000, 0, 1, 100));
		directed_rows.push_back(typed_row(REQ_INSERT, 16'd20, 16'd2, 10'd0,
			ST_LIMIT, 1, 16'h0000, 0, 1, 100));
		directed_rows.push_back(typed_row(REQ_INSERT, 16'd10, 16'd3, 10'd69,
			ST_LIMIT, 0, 16'h0000, 0, 1, 100));
		directed_rows.push_back(req_row(REQ_INSERT, 16'd10, 16'd4, 10'd10));
		// limit dropped below use: entries stay, growth is refused
		directed_rows.push_back(cfg_row(24'd0));
		directed_rows.push_back(req_row(REQ_INSERT, 16'd5, 16'd5, 10'd0));
		directed_rows.push_back(req_row(REQ_INSERT, 16'd10, 16'd6, 10'd0));
		directed_rows.push_back(req_row(REQ_LOOKUP, 16'd10, 16'd0, 10'd0));
		directed_rows.push_back(req_row(REQ_DELETE, 16'd10, 16'd0, 10'd0));
		directed_rows.push_back(cfg_row(24'hFFFFFF));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.is_cfg)
				write_limit(row.cfg_val);
			else
				send_req(row.req, row.key, row.handle, row.len, row.typed, row.want);
		end

		// Fill to capacity in scattered order; one key per high byte keeps them distinct.
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			slot = 8'(j * 167);
			send_req(REQ_INSERT, {slot, 8'($urandom)}, HANDLE_W'($urandom),
				LENGTH_W'($urandom), 1'b0, '0);
		end
		send_req(REQ_INSERT, keys_held[0] ^ 16'h0001, 16'h0F0F, 10'd1, 1'b0, '0);
		send_req(REQ_LOOKUP, keys_held[TABLE_DEPTH-1], 16'h0000, 10'd0, 1'b0, '0);
		send_req(REQ_DELETE, keys_held[128], 16'h0000, 10'd0, 1'b0, '0);
		send_req(REQ_INSERT, keys_held[127] ^ 16'h0001, 16'hF0F0, 10'd2, 1'b0, '0);
		// full table and a budget one short of a new entry: budget wins
		write_limit(BYTES_W'(budget_used + ENTRY_OVERHEAD_DEF - 1));
		send_req(REQ_INSERT, keys_held[10] ^ 16'h0001, 16'h3C3C, 10'd0, 1'b0, '0);
		send_req(REQ_INSERT, keys_held[20], 16'hC3C3, lengths_held[20], 1'b0, '0);

		// random streams under three idling patterns and three limits
		write_limit(LIMIT_RESET);
		run_random_phase(372);
		tx_idle_pct = 47;
		rx_idle_pct = 37;
		write_limit(24'hFFFFFF);
		run_random_phase(372);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_limit(BYTES_W'($urandom_range(120000, 4000)));
		run_random_phase(372);

		wait_results_in();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_ram.sv
hw/rtl/sorted_line_table_top.sv
sim/tb.sv
